// ===== src/lcc_pkg.sv =====
// Shared widths, codes and control structs for the Luhn card number check.
// No dependencies; every other file refers to it by scoped names.
package lcc_pkg;

  localparam int CARD_W     = 63;   // binary card number width
  localparam int MAX_DIGITS = 19;   // decimal digits held by the cell chain
  localparam int DIGIT_W    = 4;    // one BCD digit
  localparam int COUNT_W    = 5;    // digit_count field
  localparam int CLASS_W    = 2;    // issuer_class field
  localparam int BIT_CNT_W  = $clog2(CARD_W);
  localparam int IDX_W      = $clog2(MAX_DIGITS);

  // Decimal arithmetic constants.
  localparam int DEC_BASE     = 10;
  localparam int DABBLE_LIMIT = 5;
  localparam int DABBLE_ADJ   = 3;
  localparam int DOUBLE_FOLD  = 9;

  // Issuer class codes.
  localparam logic [CLASS_W-1:0] CLS_NONE   = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_LEN15  = 2'd1;
  localparam logic [CLASS_W-1:0] CLS_LEN16  = 2'd2;
  localparam logic [CLASS_W-1:0] CLS_LEAD4  = 2'd3;

  // Length and prefix constants for classification.
  localparam logic [COUNT_W-1:0] LEN_13 = 5'd13;
  localparam logic [COUNT_W-1:0] LEN_15 = 5'd15;
  localparam logic [COUNT_W-1:0] LEN_16 = 5'd16;

  typedef struct packed {
    logic clear;   // zero every digit
    logic dabble;  // shift one binary bit in, with add-3 correction
    logic scan;    // shift digits one place toward the low end
  } lcc_cell_ctrl_t;

  typedef struct packed {
    logic clear;   // start a new number
    logic step;    // take the low digit of the chain
    logic ovf;     // top cell carried out: too many digits
  } lcc_acc_ctrl_t;

  typedef struct packed {
    logic [CLASS_W-1:0] issuer_class;
    logic               checksum_ok;
    logic [COUNT_W-1:0] digit_count;
  } lcc_result_t;

endpackage

// ===== src/lcc_if.sv =====
// Valid/ready channel interfaces for card numbers in and check results out.
// Depends on lcc_pkg for payload widths.
interface lcc_in_if;
  logic                        valid;
  logic                        ready;
  logic [lcc_pkg::CARD_W-1:0]  card_number;

  modport source (output valid, output card_number, input ready);
  modport sink   (input valid, input card_number, output ready);
endinterface

interface lcc_out_if;
  logic                         valid;
  logic                         ready;
  logic [lcc_pkg::CLASS_W-1:0]  issuer_class;
  logic                         checksum_ok;
  logic [lcc_pkg::COUNT_W-1:0]  digit_count;

  modport source (output valid, output issuer_class, output checksum_ok,
                  output digit_count, input ready);
  modport sink   (input valid, input issuer_class, input checksum_ok,
                  input digit_count, output ready);
endinterface

// ===== src/lcc_cell.sv =====
// One BCD digit cell: double-dabble step or digit shift toward the low end.
// Depends on lcc_pkg.
module lcc_cell (
  input  logic                          clk,
  input  lcc_pkg::lcc_cell_ctrl_t       ctrl,
  input  logic                          bit_in,
  input  logic [lcc_pkg::DIGIT_W-1:0]   digit_in,
  output logic [lcc_pkg::DIGIT_W-1:0]   digit,
  output logic                          carry_out
);

  logic [lcc_pkg::DIGIT_W-1:0] corr;

  // Add 3 when the digit would reach ten after doubling.
  always_comb begin
    if (digit >= lcc_pkg::DIGIT_W'(lcc_pkg::DABBLE_LIMIT)) begin
      corr = digit + lcc_pkg::DIGIT_W'(lcc_pkg::DABBLE_ADJ);
    end else begin
      corr = digit;
    end
  end

  assign carry_out = corr[lcc_pkg::DIGIT_W-1];

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.dabble) begin
      digit <= {corr[lcc_pkg::DIGIT_W-2:0], bit_in};
    end else if (ctrl.scan) begin
      digit <= digit_in;
    end
  end

endmodule

// ===== src/lcc_digit_chain.sv =====
// Row of BCD digit cells: binary bits enter at the low cell, carries ripple
// one cell per cycle; in scan mode digits move down to the low end.
// Depends on lcc_pkg and lcc_cell.
module lcc_digit_chain (
  input  logic                          clk,
  input  lcc_pkg::lcc_cell_ctrl_t       ctrl,
  input  logic                          serial_bit,
  output logic [lcc_pkg::DIGIT_W-1:0]   digit_lo,
  output logic                          top_carry
);

  logic [lcc_pkg::DIGIT_W-1:0] digits [lcc_pkg::MAX_DIGITS];
  logic                        carry  [lcc_pkg::MAX_DIGITS];

  for (genvar i = 0; i < lcc_pkg::MAX_DIGITS; i++) begin : g_cell
    logic                        bit_in;
    logic [lcc_pkg::DIGIT_W-1:0] digit_in;

    if (i == 0) begin : g_low
      assign bit_in = serial_bit;
    end else begin : g_mid
      assign bit_in = carry[i-1];
    end

    if (i == lcc_pkg::MAX_DIGITS - 1) begin : g_top
      assign digit_in = '0;
    end else begin : g_below
      assign digit_in = digits[i+1];
    end

    lcc_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .bit_in    (bit_in),
      .digit_in  (digit_in),
      .digit     (digits[i]),
      .carry_out (carry[i])
    );
  end

  assign digit_lo  = digits[0];
  assign top_carry = carry[lcc_pkg::MAX_DIGITS-1];

endmodule

// ===== src/lcc_luhn_acc.sv =====
// Luhn accumulator: takes one decimal digit per cycle from the low end,
// keeps the sum mod 10, digit count and the two leading digits, and
// classifies the issuer. Depends on lcc_pkg.
module lcc_luhn_acc (
  input  logic                          clk,
  input  lcc_pkg::lcc_acc_ctrl_t        ctrl,
  input  logic [lcc_pkg::DIGIT_W-1:0]   digit,
  input  logic [lcc_pkg::IDX_W-1:0]     index,
  output lcc_pkg::lcc_result_t          result
);

  logic [lcc_pkg::DIGIT_W-1:0] sum;
  logic [lcc_pkg::COUNT_W-1:0] count;
  logic [lcc_pkg::DIGIT_W-1:0] lead;
  logic [lcc_pkg::DIGIT_W-1:0] second;
  logic [lcc_pkg::DIGIT_W-1:0] prev;
  logic                        ovf;

  logic [lcc_pkg::DIGIT_W:0]   twice;
  logic [lcc_pkg::DIGIT_W:0]   folded;
  logic [lcc_pkg::DIGIT_W-1:0] addend;
  logic [lcc_pkg::DIGIT_W:0]   raw;
  logic [lcc_pkg::DIGIT_W-1:0] sum_next;

  always_comb begin
    twice = {digit, 1'b0};
    if (twice >= (lcc_pkg::DIGIT_W+1)'(lcc_pkg::DEC_BASE)) begin
      folded = twice - (lcc_pkg::DIGIT_W+1)'(lcc_pkg::DOUBLE_FOLD);
    end else begin
      folded = twice;
    end
    // Odd positions from the right are doubled.
    addend = index[0] ? folded[lcc_pkg::DIGIT_W-1:0] : digit;
    raw    = {1'b0, sum} + {1'b0, addend};
    if (raw >= (lcc_pkg::DIGIT_W+1)'(lcc_pkg::DEC_BASE)) begin
      sum_next = lcc_pkg::DIGIT_W'(raw - (lcc_pkg::DIGIT_W+1)'(lcc_pkg::DEC_BASE));
    end else begin
      sum_next = raw[lcc_pkg::DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      sum    <= '0;
      count  <= '0;
      lead   <= '0;
      second <= '0;
      prev   <= '0;
      ovf    <= 1'b0;
    end else begin
      if (ctrl.ovf) begin
        ovf <= 1'b1;
      end
      if (ctrl.step) begin
        sum  <= sum_next;
        prev <= digit;
        if (digit != '0) begin
          count  <= lcc_pkg::COUNT_W'(index) + lcc_pkg::COUNT_W'(1);
          lead   <= digit;
          second <= prev;
        end
      end
    end
  end

  logic ok;
  logic pair_3x;
  logic pair_5x;

  always_comb begin
    ok      = (sum == '0);
    pair_3x = (lead == 4'd3) && (second == 4'd4 || second == 4'd7);
    pair_5x = (lead == 4'd5) && (second >= 4'd1) && (second <= 4'd5);

    result.issuer_class = lcc_pkg::CLS_NONE;
    result.checksum_ok  = ok;
    result.digit_count  = count;
    if (ovf) begin
      result.checksum_ok = 1'b0;
      result.digit_count = lcc_pkg::COUNT_W'(lcc_pkg::MAX_DIGITS);
    end else if (ok && count != '0) begin
      if (count == lcc_pkg::LEN_15 && pair_3x) begin
        result.issuer_class = lcc_pkg::CLS_LEN15;
      end else if (count == lcc_pkg::LEN_16 && pair_5x) begin
        result.issuer_class = lcc_pkg::CLS_LEN16;
      end else if ((count == lcc_pkg::LEN_13 || count == lcc_pkg::LEN_16)
                   && lead == 4'd4) begin
        result.issuer_class = lcc_pkg::CLS_LEAD4;
      end
    end
  end

endmodule

// ===== src/luhn_card_number_check.sv =====
// Top level of the Luhn card number check: sequencer, input shift register,
// BCD cell chain, Luhn accumulator and output register.
// Depends on lcc_pkg, lcc_if, lcc_digit_chain and lcc_luhn_acc.
//
//   channel     | dir | payload                                   | handshake
//   ------------+-----+-------------------------------------------+-------------
//   card_in     | in  | card_number[62:0]                         | valid/ready
//   result_out  | out | issuer_class[1:0] checksum_ok digit_count | valid/ready
//
// Each number passes through the transfer cycle itself, one bit per cycle through
// the double-dabble cell chain, one digit per cycle into the Luhn accumulator,
// then the load of the output register, from which the result is offered.
// One number is in work at a time; a new one is taken while the previous
// result still sits in the output register.
// A stall on result_out holds the finished result in the sequencer until
// the output register frees up. Reset (rst, synchronous) returns the sequencer
// to idle and empties the output register; the shift register, cell chain and
// accumulator are not reset.
module luhn_card_number_check (
  input  logic            clk,
  input  logic            rst,
  lcc_in_if.sink          card_in,
  lcc_out_if.source       result_out
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CONV   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t                           state;
  logic [lcc_pkg::CARD_W-1:0]       shreg;
  logic [lcc_pkg::BIT_CNT_W-1:0]    bit_cnt;
  logic [lcc_pkg::IDX_W-1:0]        dig_idx;
  lcc_pkg::lcc_result_t             res;
  logic                             res_valid;

  lcc_pkg::lcc_cell_ctrl_t          cell_ctrl;
  lcc_pkg::lcc_acc_ctrl_t           acc_ctrl;
  lcc_pkg::lcc_result_t             acc_result;
  logic [lcc_pkg::DIGIT_W-1:0]      digit_lo;
  logic                             top_carry;
  logic                             take;
  logic                             res_free;

  // A number transfers only while the sequencer is idle.
  assign card_in.ready = (state == ST_IDLE);
  assign take          = card_in.valid && card_in.ready;
  assign res_free      = !res_valid || result_out.ready;

  // Steer the cell chain and accumulator from the sequencer state.
  always_comb begin
    cell_ctrl.clear  = take;
    cell_ctrl.dabble = (state == ST_CONV);
    cell_ctrl.scan   = (state == ST_SCAN);

    acc_ctrl.clear   = take;
    acc_ctrl.step    = (state == ST_SCAN);
    // Any carry out of the top cell means the number has too many digits.
    acc_ctrl.ovf     = (state == ST_CONV) && top_carry;
  end

  lcc_digit_chain u_chain (
    .clk        (clk),
    .ctrl       (cell_ctrl),
    .serial_bit (shreg[lcc_pkg::CARD_W-1]),
    .digit_lo   (digit_lo),
    .top_carry  (top_carry)
  );

  lcc_luhn_acc u_acc (
    .clk    (clk),
    .ctrl   (acc_ctrl),
    .digit  (digit_lo),
    .index  (dig_idx),
    .result (acc_result)
  );

  // Sequencer: load, convert MSB first, scan digits LSB first, hand off.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      bit_cnt <= '0;
      dig_idx <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (take) begin
            bit_cnt <= '0;
            state   <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (bit_cnt == lcc_pkg::BIT_CNT_W'(lcc_pkg::CARD_W - 1)) begin
            dig_idx <= '0;
            state   <= ST_SCAN;
          end else begin
            bit_cnt <= bit_cnt + lcc_pkg::BIT_CNT_W'(1);
          end
        end
        ST_SCAN: begin
          if (dig_idx == lcc_pkg::IDX_W'(lcc_pkg::MAX_DIGITS - 1)) begin
            state <= ST_FINISH;
          end else begin
            dig_idx <= dig_idx + lcc_pkg::IDX_W'(1);
          end
        end
        ST_FINISH: begin
          if (res_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Input shift register: load on transfer, advance one bit per conversion cycle.
  always_ff @(posedge clk) begin
    if (take) begin
      shreg <= card_in.card_number;
    end else if (state == ST_CONV) begin
      shreg <= {shreg[lcc_pkg::CARD_W-2:0], 1'b0};
    end
  end

  // Output register: fill from the accumulator, drop on transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_FINISH && res_free) begin
      res_valid <= 1'b1;
    end else if (result_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && res_free) begin
      res <= acc_result;
    end
  end

  assign result_out.valid        = res_valid;
  assign result_out.issuer_class = res.issuer_class;
  assign result_out.checksum_ok  = res.checksum_ok;
  assign result_out.digit_count  = res.digit_count;

  // A transfer starts conversion on the next cycle.
  a_take_starts_conv: assert property (@(posedge clk) disable iff (rst)
    take |=> state == ST_CONV)
    else $error("transfer did not start conversion");

  // The last scan step hands over to the finishing state.
  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && dig_idx == lcc_pkg::IDX_W'(lcc_pkg::MAX_DIGITS - 1))
    |=> state == ST_FINISH)
    else $error("scan did not end after the last digit");

  // A failed checksum never carries an issuer class.
  a_bad_sum_no_class: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && !result_out.checksum_ok)
    |-> result_out.issuer_class == lcc_pkg::CLS_NONE)
    else $error("issuer class set on failed checksum");

  // Digit count never exceeds the chain length.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    result_out.valid
    |-> result_out.digit_count <= lcc_pkg::COUNT_W'(lcc_pkg::MAX_DIGITS))
    else $error("digit count out of range");

  // A result is loaded only into a free output register.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && res_valid && !result_out.ready)
    |=> state == ST_FINISH)
    else $error("result left finishing state while output was stalled");

endmodule
